@@ rtl/maze_generator_dfs_unit_defines.svh @@
// Assertion macros for the maze generator checker.
`ifndef MAZE_GENERATOR_DFS_UNIT_DEFINES_SVH
`define MAZE_GENERATOR_DFS_UNIT_DEFINES_SVH

// Clocked assertion, off while in reset.
`define MGD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion, checked in and out of reset.
`define MGD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/mgd_pkg.sv @@
// Shared types, codes and helper functions of the maze generator.
`default_nettype none
package mgd_pkg;

    localparam int COORD_W     = 5;
    localparam int COORD_MAX   = (1 << COORD_W) - 1;
    localparam int RAND_W      = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int TRIES_W     = 13;
    localparam int ENTRANCE_TRIES = 4096;
    localparam logic [RAND_W-1:0] LFSR_TAPS = 16'hB400;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RANDOM_SEED = 2'd2;

    localparam logic [1:0] ST_GENERATED = 2'd0;
    localparam logic [1:0] ST_READ_OK   = 2'd1;
    localparam logic [1:0] ST_OUTSIDE   = 2'd2;

    localparam logic OP_GENERATE = 1'b0;
    localparam logic OP_READ     = 1'b1;

    // walk directions; also border sides for entrances
    localparam logic [1:0] DIR_WEST  = 2'd0;
    localparam logic [1:0] DIR_EAST  = 2'd1;
    localparam logic [1:0] DIR_NORTH = 2'd2;
    localparam logic [1:0] DIR_SOUTH = 2'd3;

    typedef enum logic [4:0] {
        DP_NOP,
        DP_ACCEPT,
        DP_RES_OUTSIDE,
        DP_RES_CELL,
        DP_RES_GEN,
        DP_OUT_LOAD,
        DP_GEN_INIT,
        DP_FILL,
        DP_DRAW_MOD,
        DP_TAKE_REM,
        DP_ENTER,
        DP_SHUFFLE,
        DP_STEP,
        DP_OPEN_MID,
        DP_PUSH,
        DP_POP,
        DP_LOAD_TOP,
        DP_SIDES_INIT,
        DP_ENT_OPEN,
        DP_NEXT_SIDE
    } dp_op_t;

    typedef enum logic [1:0] {
        DIV_HALF_W,
        DIV_HALF_H,
        DIV_ENT
    } div_sel_t;

    typedef struct packed {
        dp_op_t   op;
        div_sel_t div_sel;
    } dp_cmd_t;

    typedef struct packed {
        logic fill_last;
        logic mod_busy;
        logic exhausted;
        logic nb_out;
        logic rd_open;
        logic stack_full;
        logic sp_one;
        logic shuf_last;
        logic side_last;
        logic tries_max;
        logic in_is_read;
        logic outside;
    } dp_status_t;

    function automatic logic [RAND_W-1:0] lfsr_step(input logic [RAND_W-1:0] r);
        logic [RAND_W-1:0] n;
        n = {1'b0, r[RAND_W-1:1]};
        if (r[0])
        begin
            n = n ^ LFSR_TAPS;
        end
        return n;
    endfunction

    function automatic logic [COORD_W-1:0] effective(input logic [COORD_W-1:0] v,
                                                     input logic [COORD_W-1:0] top);
        logic [COORD_W-1:0] e;
        e = v;
        if (!e[0])
        begin
            e = (e == '0) ? '0 : e - 1'b1;
        end
        if (e < COORD_W'(3))
        begin
            e = COORD_W'(3);
        end
        if (e > top)
        begin
            e = top;
        end
        return e;
    endfunction

endpackage
`default_nettype wire

@@ rtl/mgd_mod.sv @@
// Bit-serial remainder unit: 16-bit dividend modulo a 5-bit divisor.
`default_nettype none
module mgd_mod (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [mgd_pkg::RAND_W-1:0]    dividend,
    input  wire logic [mgd_pkg::COORD_W-1:0]   divisor,
    output logic                               busy,
    output logic [mgd_pkg::COORD_W-1:0]        remainder
);
    localparam int CNT_W = $clog2(mgd_pkg::RAND_W);

    logic                          busy_reg;
    logic [CNT_W-1:0]              cnt_reg;
    logic [mgd_pkg::RAND_W-1:0]    dvd_reg;
    logic [mgd_pkg::COORD_W-1:0]   dvs_reg;
    logic [mgd_pkg::COORD_W-1:0]   rem_reg;
    logic [mgd_pkg::COORD_W:0]     partial;
    logic [mgd_pkg::COORD_W:0]     rem_next;

    always_comb
    begin
        partial  = {rem_reg, dvd_reg[mgd_pkg::RAND_W-1]};
        rem_next = partial;
        if (partial >= {1'b0, dvs_reg})
        begin
            rem_next = partial - {1'b0, dvs_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(mgd_pkg::RAND_W - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[mgd_pkg::RAND_W-2:0], 1'b0};
            rem_reg <= rem_next[mgd_pkg::COORD_W-1:0];
        end
    end

    assign busy      = busy_reg;
    assign remainder = rem_reg;
endmodule
`default_nettype wire

@@ rtl/mgd_datapath.sv @@
// Maze datapath: config, LFSR, wall map, walk stack, top frame and result registers.
`default_nettype none
module mgd_datapath #(
    parameter int MAX_WIDTH   = 32,
    parameter int MAX_HEIGHT  = 32,
    parameter int STACK_DEPTH = 256
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire mgd_pkg::dp_cmd_t                 cmd,
    output mgd_pkg::dp_status_t                   dp_status,
    input  wire logic                             cfg_we,
    input  wire logic [mgd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [mgd_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                             operation,
    input  wire logic [mgd_pkg::COORD_W-1:0]      cell_row,
    input  wire logic [mgd_pkg::COORD_W-1:0]      cell_column,
    output logic                                  cell_is_wall,
    output logic [1:0]                            result_status
);
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int AW    = RW + CW;
    localparam int SAW   = $clog2(STACK_DEPTH);
    localparam int SPW   = $clog2(STACK_DEPTH + 1);
    localparam int TOP_W = (MAX_WIDTH % 2 == 1) ? MAX_WIDTH : MAX_WIDTH - 1;
    localparam int TOP_H = (MAX_HEIGHT % 2 == 1) ? MAX_HEIGHT : MAX_HEIGHT - 1;
    localparam int LIM_W = (TOP_W > mgd_pkg::COORD_MAX) ? mgd_pkg::COORD_MAX : TOP_W;
    localparam int LIM_H = (TOP_H > mgd_pkg::COORD_MAX) ? mgd_pkg::COORD_MAX : TOP_H;
    localparam int K     = mgd_pkg::COORD_W;
    localparam int FW    = 2 * K + 8 + 3;

    typedef logic [K-1:0] coord_t;

    function automatic logic [AW-1:0] cell_addr(input coord_t r, input coord_t c);
        return {RW'(r), CW'(c)};
    endfunction

    // configuration
    coord_t                        grid_width_reg;
    coord_t                        grid_height_reg;
    logic [mgd_pkg::RAND_W-1:0]    seed_reg;
    coord_t                        w;
    coord_t                        h;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= K'(21);
            grid_height_reg <= K'(21);
            seed_reg        <= 16'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mgd_pkg::CFG_GRID_WIDTH:  grid_width_reg  <= cfg_data[K-1:0];
                mgd_pkg::CFG_GRID_HEIGHT: grid_height_reg <= cfg_data[K-1:0];
                mgd_pkg::CFG_RANDOM_SEED: seed_reg        <= cfg_data;
                default: ;
            endcase
        end
    end

    assign w = mgd_pkg::effective(grid_width_reg, K'(LIM_W));
    assign h = mgd_pkg::effective(grid_height_reg, K'(LIM_H));

    // working registers
    logic [mgd_pkg::RAND_W-1:0]    lfsr_reg;
    logic [mgd_pkg::RAND_W-1:0]    lfsr_next;
    logic [AW-1:0]                 fill_cnt_reg;
    logic [SPW-1:0]                sp_reg;
    coord_t                        top_row_reg;
    coord_t                        top_col_reg;
    logic [3:0][1:0]               order_reg;
    logic [2:0]                    next_reg;
    logic [1:0]                    idx_reg;
    coord_t                        cand_row_reg;
    coord_t                        cand_col_reg;
    coord_t                        rd_row_reg;
    coord_t                        rd_col_reg;
    coord_t                        ent_row_reg;
    coord_t                        ent_col_reg;
    logic                          side_i_reg;
    logic [mgd_pkg::TRIES_W-1:0]   tries_reg;
    logic                          pend_wall_reg;
    logic [1:0]                    pend_status_reg;
    logic                          out_wall_reg;
    logic [1:0]                    out_status_reg;

    assign lfsr_next = mgd_pkg::lfsr_step(lfsr_reg);

    // remainder unit
    logic                          mod_start;
    logic                          mod_busy;
    coord_t                        mod_rem;
    coord_t                        divisor;
    logic [1:0]                    side;
    logic                          side_is_row;

    assign side        = order_reg[{1'b0, side_i_reg}];
    assign side_is_row = !side[1];
    assign mod_start   = (cmd.op == mgd_pkg::DP_DRAW_MOD);

    always_comb
    begin
        case (cmd.div_sel)
            mgd_pkg::DIV_HALF_W: divisor = w >> 1;
            mgd_pkg::DIV_HALF_H: divisor = h >> 1;
            mgd_pkg::DIV_ENT:    divisor = side_is_row ? h : w;
            default:             divisor = w;
        endcase
    end

    mgd_mod u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (lfsr_next),
        .divisor   (divisor),
        .busy      (mod_busy),
        .remainder (mod_rem)
    );

    // neighbor of the top frame
    logic [1:0]  dir;
    logic [K:0]  nb_r;
    logic [K:0]  nb_c;
    logic        nb_out;

    always_comb
    begin
        dir    = order_reg[next_reg[1:0]];
        nb_r   = {1'b0, top_row_reg};
        nb_c   = {1'b0, top_col_reg};
        nb_out = 1'b0;
        case (dir)
            mgd_pkg::DIR_WEST:
            begin
                nb_c   = nb_c - (K+1)'(2);
                nb_out = top_col_reg < K'(2);
            end
            mgd_pkg::DIR_EAST:
            begin
                nb_c   = nb_c + (K+1)'(2);
                nb_out = nb_c >= {1'b0, w};
            end
            mgd_pkg::DIR_NORTH:
            begin
                nb_r   = nb_r - (K+1)'(2);
                nb_out = top_row_reg < K'(2);
            end
            default:
            begin
                nb_r   = nb_r + (K+1)'(2);
                nb_out = nb_r >= {1'b0, h};
            end
        endcase
    end

    // entrance cells from the remainder
    coord_t inner_row;
    coord_t inner_col;
    coord_t outer_row;
    coord_t outer_col;

    always_comb
    begin
        if (side_is_row)
        begin
            inner_row = mod_rem;
            outer_row = mod_rem;
            inner_col = (side == mgd_pkg::DIR_WEST) ? K'(1) : w - K'(2);
            outer_col = (side == mgd_pkg::DIR_WEST) ? K'(0) : w - K'(1);
        end
        else
        begin
            inner_col = mod_rem;
            outer_col = mod_rem;
            inner_row = (side == mgd_pkg::DIR_NORTH) ? K'(1) : h - K'(2);
            outer_row = (side == mgd_pkg::DIR_NORTH) ? K'(0) : h - K'(1);
        end
    end

    // wall map
    logic            wall_mem [2**AW];
    logic            wall_rdata_reg;
    logic            wall_we;
    logic            wall_wdata;
    logic [AW-1:0]   wall_waddr;
    logic            wall_re;
    logic [AW-1:0]   wall_raddr;
    logic [K:0]      mid_r;
    logic [K:0]      mid_c;

    assign mid_r = ({1'b0, top_row_reg} + {1'b0, cand_row_reg}) >> 1;
    assign mid_c = ({1'b0, top_col_reg} + {1'b0, cand_col_reg}) >> 1;

    always_comb
    begin
        wall_we    = 1'b0;
        wall_wdata = 1'b0;
        wall_waddr = fill_cnt_reg;
        case (cmd.op)
            mgd_pkg::DP_FILL:
            begin
                wall_we    = 1'b1;
                wall_wdata = 1'b1;
            end
            mgd_pkg::DP_ENTER:
            begin
                wall_we    = 1'b1;
                wall_waddr = cell_addr(cand_row_reg, cand_col_reg);
            end
            mgd_pkg::DP_OPEN_MID:
            begin
                wall_we    = 1'b1;
                wall_waddr = cell_addr(mid_r[K-1:0], mid_c[K-1:0]);
            end
            mgd_pkg::DP_ENT_OPEN:
            begin
                wall_we    = 1'b1;
                wall_waddr = cell_addr(ent_row_reg, ent_col_reg);
            end
            default: ;
        endcase
    end

    always_comb
    begin
        wall_re    = 1'b0;
        wall_raddr = cell_addr(cell_row, cell_column);
        case (cmd.op)
            mgd_pkg::DP_ACCEPT:
            begin
                wall_re = 1'b1;
            end
            mgd_pkg::DP_STEP:
            begin
                wall_re    = 1'b1;
                wall_raddr = cell_addr(nb_r[K-1:0], nb_c[K-1:0]);
            end
            mgd_pkg::DP_TAKE_REM:
            begin
                wall_re    = (cmd.div_sel == mgd_pkg::DIV_ENT);
                wall_raddr = cell_addr(inner_row, inner_col);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wall_we)
        begin
            wall_mem[wall_waddr] <= wall_wdata;
        end
        if (wall_re)
        begin
            wall_rdata_reg <= wall_mem[wall_raddr];
        end
    end

    // walk stack: frames below the top one
    logic [FW-1:0]   stack_mem [STACK_DEPTH];
    logic [FW-1:0]   stack_rdata_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.op == mgd_pkg::DP_PUSH)
        begin
            stack_mem[SAW'(sp_reg - SPW'(1))] <=
                {top_row_reg, top_col_reg, order_reg, next_reg};
        end
        if (cmd.op == mgd_pkg::DP_POP)
        begin
            stack_rdata_reg <= stack_mem[SAW'(sp_reg - SPW'(2))];
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_cnt_reg <= '0;
            sp_reg       <= '0;
            lfsr_reg     <= 16'd1;
        end
        else
        begin
            case (cmd.op)
                mgd_pkg::DP_FILL:     fill_cnt_reg <= fill_cnt_reg + 1'b1;
                mgd_pkg::DP_GEN_INIT:
                begin
                    sp_reg   <= '0;
                    lfsr_reg <= (seed_reg == '0) ? 16'd1 : seed_reg;
                end
                mgd_pkg::DP_DRAW_MOD: lfsr_reg <= lfsr_next;
                mgd_pkg::DP_SHUFFLE:  lfsr_reg <= lfsr_next;
                mgd_pkg::DP_ENTER:    sp_reg   <= sp_reg + 1'b1;
                mgd_pkg::DP_POP:      sp_reg   <= sp_reg - 1'b1;
                default: ;
            endcase
        end
    end

    // payload registers
    logic [3:0][1:0] order_swapped;
    logic [1:0]      swap_j;

    always_comb
    begin
        swap_j                 = lfsr_next[1:0];
        order_swapped          = order_reg;
        order_swapped[idx_reg] = order_reg[swap_j];
        order_swapped[swap_j]  = order_reg[idx_reg];
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            mgd_pkg::DP_ACCEPT:
            begin
                rd_row_reg <= cell_row;
                rd_col_reg <= cell_column;
            end
            mgd_pkg::DP_RES_OUTSIDE:
            begin
                pend_wall_reg   <= 1'b0;
                pend_status_reg <= mgd_pkg::ST_OUTSIDE;
            end
            mgd_pkg::DP_RES_CELL:
            begin
                pend_wall_reg   <= wall_rdata_reg;
                pend_status_reg <= mgd_pkg::ST_READ_OK;
            end
            mgd_pkg::DP_RES_GEN:
            begin
                pend_wall_reg   <= 1'b0;
                pend_status_reg <= mgd_pkg::ST_GENERATED;
            end
            mgd_pkg::DP_OUT_LOAD:
            begin
                out_wall_reg   <= pend_wall_reg;
                out_status_reg <= pend_status_reg;
            end
            mgd_pkg::DP_TAKE_REM:
            begin
                case (cmd.div_sel)
                    mgd_pkg::DIV_HALF_W: cand_col_reg <= {mod_rem[K-2:0], 1'b1};
                    mgd_pkg::DIV_HALF_H: cand_row_reg <= {mod_rem[K-2:0], 1'b1};
                    default:
                    begin
                        ent_row_reg <= outer_row;
                        ent_col_reg <= outer_col;
                        tries_reg   <= tries_reg + 1'b1;
                    end
                endcase
            end
            mgd_pkg::DP_ENTER:
            begin
                top_row_reg <= cand_row_reg;
                top_col_reg <= cand_col_reg;
                order_reg   <= {2'd3, 2'd2, 2'd1, 2'd0};
                next_reg    <= '0;
                idx_reg     <= '0;
            end
            mgd_pkg::DP_SHUFFLE:
            begin
                order_reg <= order_swapped;
                idx_reg   <= idx_reg + 1'b1;
            end
            mgd_pkg::DP_STEP:
            begin
                next_reg     <= next_reg + 1'b1;
                cand_row_reg <= nb_r[K-1:0];
                cand_col_reg <= nb_c[K-1:0];
            end
            mgd_pkg::DP_LOAD_TOP:
            begin
                {top_row_reg, top_col_reg, order_reg, next_reg} <= stack_rdata_reg;
            end
            mgd_pkg::DP_SIDES_INIT:
            begin
                order_reg  <= {2'd3, 2'd2, 2'd1, 2'd0};
                idx_reg    <= '0;
                side_i_reg <= 1'b0;
                tries_reg  <= '0;
            end
            mgd_pkg::DP_NEXT_SIDE:
            begin
                side_i_reg <= 1'b1;
                tries_reg  <= '0;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        dp_status.fill_last  = (fill_cnt_reg == '1);
        dp_status.mod_busy   = mod_busy;
        dp_status.exhausted  = next_reg[2];
        dp_status.nb_out     = nb_out;
        dp_status.rd_open    = !wall_rdata_reg;
        dp_status.stack_full = (sp_reg >= SPW'(STACK_DEPTH));
        dp_status.sp_one     = (sp_reg == SPW'(1));
        dp_status.shuf_last  = (idx_reg == 2'd3);
        dp_status.side_last  = side_i_reg;
        dp_status.tries_max  = (tries_reg == mgd_pkg::TRIES_W'(mgd_pkg::ENTRANCE_TRIES));
        dp_status.in_is_read = (operation == mgd_pkg::OP_READ);
        dp_status.outside    = (rd_row_reg >= h) || (rd_col_reg >= w);
    end

    assign cell_is_wall  = out_wall_reg;
    assign result_status = out_status_reg;
endmodule
`default_nettype wire

@@ rtl/mgd_ctrl.sv @@
// Maze controller: sequences reads, the clearing pass, the walk and the entrances.
`default_nettype none
module mgd_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output mgd_pkg::dp_cmd_t           cmd,
    input  wire mgd_pkg::dp_status_t   dp_status
);
    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_RD, S_GINIT, S_FILL,
        S_DRAW_C, S_WAIT_C, S_DRAW_R, S_WAIT_R,
        S_ENTER, S_SHUF, S_WALK, S_LOAD, S_WCHK, S_PUSH,
        S_SIDES, S_SSHUF, S_EDRAW, S_EWAIT, S_ECHK, S_NSIDE, S_WOUT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        cmd.op         = mgd_pkg::DP_NOP;
        cmd.div_sel    = mgd_pkg::DIV_ENT;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.op = mgd_pkg::DP_FILL;
                if (dp_status.fill_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = mgd_pkg::DP_ACCEPT;
                    state_next = dp_status.in_is_read ? S_RD : S_GINIT;
                end
            end
            S_RD:
            begin
                cmd.op     = dp_status.outside ? mgd_pkg::DP_RES_OUTSIDE
                                               : mgd_pkg::DP_RES_CELL;
                state_next = S_WOUT;
            end
            S_GINIT:
            begin
                cmd.op     = mgd_pkg::DP_GEN_INIT;
                state_next = S_FILL;
            end
            S_FILL:
            begin
                cmd.op = mgd_pkg::DP_FILL;
                if (dp_status.fill_last)
                begin
                    state_next = S_DRAW_C;
                end
            end
            S_DRAW_C:
            begin
                cmd.op      = mgd_pkg::DP_DRAW_MOD;
                cmd.div_sel = mgd_pkg::DIV_HALF_W;
                state_next  = S_WAIT_C;
            end
            S_WAIT_C:
            begin
                cmd.div_sel = mgd_pkg::DIV_HALF_W;
                if (!dp_status.mod_busy)
                begin
                    cmd.op     = mgd_pkg::DP_TAKE_REM;
                    state_next = S_DRAW_R;
                end
            end
            S_DRAW_R:
            begin
                cmd.op      = mgd_pkg::DP_DRAW_MOD;
                cmd.div_sel = mgd_pkg::DIV_HALF_H;
                state_next  = S_WAIT_R;
            end
            S_WAIT_R:
            begin
                cmd.div_sel = mgd_pkg::DIV_HALF_H;
                if (!dp_status.mod_busy)
                begin
                    cmd.op     = mgd_pkg::DP_TAKE_REM;
                    state_next = S_ENTER;
                end
            end
            S_ENTER:
            begin
                cmd.op     = mgd_pkg::DP_ENTER;
                state_next = S_SHUF;
            end
            S_SHUF:
            begin
                cmd.op = mgd_pkg::DP_SHUFFLE;
                if (dp_status.shuf_last)
                begin
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                if (dp_status.exhausted)
                begin
                    cmd.op     = mgd_pkg::DP_POP;
                    state_next = dp_status.sp_one ? S_SIDES : S_LOAD;
                end
                else
                begin
                    cmd.op     = mgd_pkg::DP_STEP;
                    state_next = dp_status.nb_out ? S_WALK : S_WCHK;
                end
            end
            S_LOAD:
            begin
                cmd.op     = mgd_pkg::DP_LOAD_TOP;
                state_next = S_WALK;
            end
            S_WCHK:
            begin
                if (dp_status.rd_open || dp_status.stack_full)
                begin
                    state_next = S_WALK;
                end
                else
                begin
                    cmd.op     = mgd_pkg::DP_OPEN_MID;
                    state_next = S_PUSH;
                end
            end
            S_PUSH:
            begin
                cmd.op     = mgd_pkg::DP_PUSH;
                state_next = S_ENTER;
            end
            S_SIDES:
            begin
                cmd.op     = mgd_pkg::DP_SIDES_INIT;
                state_next = S_SSHUF;
            end
            S_SSHUF:
            begin
                cmd.op = mgd_pkg::DP_SHUFFLE;
                if (dp_status.shuf_last)
                begin
                    state_next = S_EDRAW;
                end
            end
            S_EDRAW:
            begin
                cmd.op     = mgd_pkg::DP_DRAW_MOD;
                state_next = S_EWAIT;
            end
            S_EWAIT:
            begin
                if (!dp_status.mod_busy)
                begin
                    cmd.op     = mgd_pkg::DP_TAKE_REM;
                    state_next = S_ECHK;
                end
            end
            S_ECHK:
            begin
                if (dp_status.rd_open)
                begin
                    cmd.op     = mgd_pkg::DP_ENT_OPEN;
                    state_next = S_NSIDE;
                end
                else if (dp_status.tries_max)
                begin
                    state_next = S_NSIDE;
                end
                else
                begin
                    state_next = S_EDRAW;
                end
            end
            S_NSIDE:
            begin
                if (dp_status.side_last)
                begin
                    cmd.op     = mgd_pkg::DP_RES_GEN;
                    state_next = S_WOUT;
                end
                else
                begin
                    cmd.op     = mgd_pkg::DP_NEXT_SIDE;
                    state_next = S_EDRAW;
                end
            end
            S_WOUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.op         = mgd_pkg::DP_OUT_LOAD;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
endmodule
`default_nettype wire

@@ rtl/maze_generator_dfs_unit.sv @@
// Top level of the depth-first maze generator with cell read-back.
// After reset the wall map is swept to all walls, one cell a cycle over all
// 2**(clog2(MAX_HEIGHT)+clog2(MAX_WIDTH)) cells (1024 by default); no item is
// accepted until it ends, config writes are always taken. A read passes through
// the S_RD and S_WOUT states to its result beat. A generate sweeps the map again,
// then walks the grid; the draws that need a remainder (start column and start
// row) and each entrance try with its check wait on the bit-serial remainder unit.
// One item is worked at a time; a new item is taken while the previous result
// beat still waits on the output.
`default_nettype none
module maze_generator_dfs_unit #(
    parameter int MAX_WIDTH   = 32,
    parameter int MAX_HEIGHT  = 32,
    parameter int STACK_DEPTH = 256
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic                             operation,
    input  wire logic [mgd_pkg::COORD_W-1:0]      cell_row,
    input  wire logic [mgd_pkg::COORD_W-1:0]      cell_column,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic                                  cell_is_wall,
    output logic [1:0]                            status,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [mgd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [mgd_pkg::CFG_DATA_W-1:0]   cfg_data
);
    mgd_pkg::dp_cmd_t    cmd;
    mgd_pkg::dp_status_t dp_status;

    assign cfg_ready = 1'b1;

    mgd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .dp_status (dp_status)
    );

    mgd_datapath #(
        .MAX_WIDTH   (MAX_WIDTH),
        .MAX_HEIGHT  (MAX_HEIGHT),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .dp_status     (dp_status),
        .cfg_we        (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .operation     (operation),
        .cell_row      (cell_row),
        .cell_column   (cell_column),
        .cell_is_wall  (cell_is_wall),
        .result_status (status)
    );
endmodule
`default_nettype wire

@@ rtl/mgd_checker.sv @@
// Port-level checker for the maze generator and its bind.
`default_nettype none
`include "maze_generator_dfs_unit_defines.svh"
module mgd_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic        cell_is_wall,
    input wire logic [1:0]  status
);
    `MGD_ASSERT(out_hold, out_valid && !out_ready |=> out_valid && $stable(status) && $stable(cell_is_wall), "result beat changed while stalled")
    `MGD_ASSERT_ALWAYS(status_code, out_valid |-> status <= mgd_pkg::ST_OUTSIDE, "undefined status code")
    `MGD_ASSERT(wall_only_read, out_valid && status != mgd_pkg::ST_READ_OK |-> !cell_is_wall, "wall bit on non-read result")
    `MGD_ASSERT(busy_after_accept, in_valid && in_ready |=> !in_ready, "accepted a second beat back to back")
endmodule

bind maze_generator_dfs_unit mgd_checker u_mgd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .cell_is_wall (cell_is_wall),
    .status       (status)
);
`default_nettype wire

@@ sim/maze_generator_dfs_unit_checker.sv @@
// Checker for the maze generator: watches all channels, predicts results, compares.
`timescale 1ns / 100ps
module maze_generator_dfs_unit_checker (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    input  wire logic                           in_ready,
    input  wire logic                           operation,
    input  wire logic [mgd_pkg::COORD_W-1:0]    cell_row,
    input  wire logic [mgd_pkg::COORD_W-1:0]    cell_column,
    input  wire logic                           out_valid,
    input  wire logic                           out_ready,
    input  wire logic                           cell_is_wall,
    input  wire logic [1:0]                     status,
    input  wire logic                           cfg_valid,
    input  wire logic                           cfg_ready,
    input  wire logic [mgd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [mgd_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                                  fail_count,
    output int                                  pending
);
    localparam int MAP_W       = 32;
    localparam int STACK_SLOTS = 256;
    localparam int MAX_ODD     = 31;

    typedef struct {
        logic       wall;
        logic [1:0] st;
    } cell_result_t;

    cell_result_t expected_q[$];

    logic [4:0]  width_reg;
    logic [4:0]  height_reg;
    logic [15:0] seed_reg;
    logic [15:0] lfsr;
    bit          wall_bits[MAP_W*MAP_W];
    bit          seen_bits[MAP_W*MAP_W];
    int          frame_row[STACK_SLOTS];
    int          frame_col[STACK_SLOTS];
    logic [1:0]  frame_dir[STACK_SLOTS][4];
    int          frame_next[STACK_SLOTS];
    int          depth;

    function automatic int eff_size(input int v);
        int e;
        e = v;
        if (e % 2 == 0)
        begin
            e = (e == 0) ? 0 : e - 1;
        end
        if (e < 3)
        begin
            e = 3;
        end
        if (e > MAX_ODD)
        begin
            e = MAX_ODD;
        end
        return e;
    endfunction

    function int next_rand();
        logic lsb;
        lsb  = lfsr[0];
        lfsr = {1'b0, lfsr[15:1]};
        if (lsb)
        begin
            lfsr = lfsr ^ 16'hB400;
        end
        return int'(lfsr);
    endfunction

    task automatic visit_cell(input int r, input int c);
        int         j;
        logic [1:0] t;
        seen_bits[r*MAP_W+c] = 1'b1;
        wall_bits[r*MAP_W+c] = 1'b0;
        frame_row[depth] = r;
        frame_col[depth] = c;
        for (int i = 0; i < 4; i++)
        begin
            frame_dir[depth][i] = 2'(i);
        end
        for (int i = 0; i < 4; i++)
        begin
            j = next_rand() % 4;
            t = frame_dir[depth][i];
            frame_dir[depth][i] = frame_dir[depth][j];
            frame_dir[depth][j] = t;
        end
        frame_next[depth] = 0;
        depth++;
    endtask

    task automatic build_maze();
        int         w, h, sc, sr, top, dr, dc, nr, nc, j, inner, outer, k;
        logic [1:0] sides[4];
        logic [1:0] t;
        w = eff_size(int'(width_reg));
        h = eff_size(int'(height_reg));
        lfsr = (seed_reg == 16'd0) ? 16'd1 : seed_reg;
        for (int i = 0; i < MAP_W*MAP_W; i++)
        begin
            wall_bits[i] = 1'b1;
            seen_bits[i] = 1'b0;
        end
        depth = 0;
        sc = (next_rand() % (w / 2)) * 2 + 1;
        sr = (next_rand() % (h / 2)) * 2 + 1;
        wall_bits[sr*MAP_W+sc] = 1'b0;
        visit_cell(sr, sc);
        while (depth > 0)
        begin
            top = depth - 1;
            if (frame_next[top] >= 4)
            begin
                depth--;
                continue;
            end
            dr = 0;
            dc = 0;
            case (frame_dir[top][frame_next[top]])
                mgd_pkg::DIR_WEST:  dc = -2;
                mgd_pkg::DIR_EAST:  dc = 2;
                mgd_pkg::DIR_NORTH: dr = -2;
                default:            dr = 2;
            endcase
            frame_next[top]++;
            nr = frame_row[top] + dr;
            nc = frame_col[top] + dc;
            if (nr < 0 || nr >= h || nc < 0 || nc >= w)
            begin
                continue;
            end
            if (seen_bits[nr*MAP_W+nc] || depth >= STACK_SLOTS)
            begin
                continue;
            end
            wall_bits[(frame_row[top] + nr) / 2 * MAP_W + (frame_col[top] + nc) / 2] = 1'b0;
            visit_cell(nr, nc);
        end
        for (int i = 0; i < 4; i++)
        begin
            sides[i] = 2'(i);
        end
        for (int i = 0; i < 4; i++)
        begin
            j = next_rand() % 4;
            t = sides[i];
            sides[i] = sides[j];
            sides[j] = t;
        end
        for (int i = 0; i < 2; i++)
        begin
            for (int n = 0; n < mgd_pkg::ENTRANCE_TRIES; n++)
            begin
                if (sides[i] == mgd_pkg::DIR_WEST || sides[i] == mgd_pkg::DIR_EAST)
                begin
                    k = next_rand() % h;
                    inner = k * MAP_W + ((sides[i] == mgd_pkg::DIR_WEST) ? 1 : w - 2);
                    outer = k * MAP_W + ((sides[i] == mgd_pkg::DIR_WEST) ? 0 : w - 1);
                end
                else
                begin
                    k = next_rand() % w;
                    inner = ((sides[i] == mgd_pkg::DIR_NORTH) ? 1 : h - 2) * MAP_W + k;
                    outer = ((sides[i] == mgd_pkg::DIR_NORTH) ? 0 : h - 1) * MAP_W + k;
                end
                if (!wall_bits[inner])
                begin
                    wall_bits[outer] = 1'b0;
                    break;
                end
            end
        end
    endtask

    assign pending = expected_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        cell_result_t exp_r;
        int           w, h;
        if (!rst_n)
        begin
            width_reg  <= 5'd21;
            height_reg <= 5'd21;
            seed_reg   <= 16'd1;
            fail_count <= 0;
            for (int i = 0; i < MAP_W*MAP_W; i++)
            begin
                wall_bits[i] = 1'b1;
                seen_bits[i] = 1'b0;
            end
            depth = 0;
            lfsr  = 16'd1;
            expected_q.delete();
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                if (operation == mgd_pkg::OP_GENERATE)
                begin
                    build_maze();
                    exp_r.wall = 1'b0;
                    exp_r.st   = mgd_pkg::ST_GENERATED;
                end
                else
                begin
                    w = eff_size(int'(width_reg));
                    h = eff_size(int'(height_reg));
                    if (int'(cell_row) >= h || int'(cell_column) >= w)
                    begin
                        exp_r.wall = 1'b0;
                        exp_r.st   = mgd_pkg::ST_OUTSIDE;
                    end
                    else
                    begin
                        exp_r.wall = wall_bits[int'(cell_row)*MAP_W + int'(cell_column)];
                        exp_r.st   = mgd_pkg::ST_READ_OK;
                    end
                end
                expected_q.push_back(exp_r);
            end
            if (out_valid && out_ready)
            begin
                if (expected_q.size() == 0)
                begin
                    if (fail_count < 10)
                    begin
                        $display("unexpected result beat: wall %0b status %0d",
                                 cell_is_wall, status);
                    end
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_r = expected_q.pop_front();
                    if (exp_r.wall !== cell_is_wall || exp_r.st !== status)
                    begin
                        if (fail_count < 10)
                        begin
                            $display("mismatch: expected wall %0b status %0d, got wall %0b status %0d",
                                     exp_r.wall, exp_r.st, cell_is_wall, status);
                        end
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    mgd_pkg::CFG_GRID_WIDTH:  width_reg  <= cfg_data[4:0];
                    mgd_pkg::CFG_GRID_HEIGHT: height_reg <= cfg_data[4:0];
                    mgd_pkg::CFG_RANDOM_SEED: seed_reg   <= cfg_data;
                    default: ;
                endcase
            end
        end
    end
endmodule

@@ sim/maze_generator_dfs_unit_tb.sv @@
// Testbench top for the maze generator: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module maze_generator_dfs_unit_tb;
    localparam int CYCLE_LIMIT = 3000000;

    logic                           clk;
    logic                           rst_n;
    logic                           in_valid;
    logic                           in_ready;
    logic                           operation;
    logic [mgd_pkg::COORD_W-1:0]    cell_row;
    logic [mgd_pkg::COORD_W-1:0]    cell_column;
    logic                           out_valid;
    logic                           out_ready;
    logic                           cell_is_wall;
    logic [1:0]                     status;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [mgd_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [mgd_pkg::CFG_DATA_W-1:0] cfg_data;
    int                             fail_count;
    int                             pending;
    int                             cycle_count;
    bit                             hold_request;
    int                             cur_w;
    int                             cur_h;

    maze_generator_dfs_unit u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .operation(operation), .cell_row(cell_row), .cell_column(cell_column),
        .out_valid(out_valid), .out_ready(out_ready),
        .cell_is_wall(cell_is_wall), .status(status),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    maze_generator_dfs_unit_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .operation(operation), .cell_row(cell_row), .cell_column(cell_column),
        .out_valid(out_valid), .out_ready(out_ready),
        .cell_is_wall(cell_is_wall), .status(status),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50)
        begin
            return 0;
        end
        else if (p < 92)
        begin
            return $urandom_range(1, 4);
        end
        return $urandom_range(20, 80);
    endfunction

    // result side: random stalls, plus one long hold-off on request
    initial
    begin
        int n;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                out_ready <= 1'b0;
                for (int i = 0; i < 400; i++)
                begin
                    @(negedge clk);
                end
                hold_request = 1'b0;
                out_ready <= 1'b1;
            end
            else
            begin
                n = gap_len();
                if (n == 0)
                begin
                    out_ready <= 1'b1;
                end
                else
                begin
                    out_ready <= 1'b0;
                    for (int i = 1; i < n; i++)
                    begin
                        @(negedge clk);
                    end
                end
            end
        end
    end

    task automatic send_beat(input logic op, input int r, input int c);
        int n;
        in_valid    <= 1'b1;
        operation   <= op;
        cell_row    <= mgd_pkg::COORD_W'(r);
        cell_column <= mgd_pkg::COORD_W'(c);
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        @(negedge clk);
        n = gap_len();
        if (n > 0)
        begin
            in_valid <= 1'b0;
            for (int i = 1; i < n; i++)
            begin
                @(negedge clk);
            end
            @(negedge clk);
        end
    endtask

    task automatic write_reg(input logic [mgd_pkg::CFG_IDX_W-1:0] idx, input int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= mgd_pkg::CFG_DATA_W'(value);
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0)
        begin
            @(negedge clk);
        end
        for (int i = 0; i < 10; i++)
        begin
            @(negedge clk);
        end
    endtask

    function automatic int odd_size(input int v);
        int e;
        e = (v % 2 == 0) ? ((v == 0) ? 0 : v - 1) : v;
        return (e < 3) ? 3 : e;
    endfunction

    task automatic set_grid(input int w, input int h, input int seed);
        write_reg(mgd_pkg::CFG_GRID_WIDTH, w);
        write_reg(mgd_pkg::CFG_GRID_HEIGHT, h);
        write_reg(mgd_pkg::CFG_RANDOM_SEED, seed);
        cur_w = odd_size(w);
        cur_h = odd_size(h);
    endtask

    task automatic random_beats(input int count);
        int p;
        for (int i = 0; i < count; i++)
        begin
            p = $urandom_range(0, 99);
            if (p < 12)
            begin
                send_beat(mgd_pkg::OP_GENERATE, $urandom_range(0, 31), $urandom_range(0, 31));
            end
            else if (p < 75)
            begin
                send_beat(mgd_pkg::OP_READ, $urandom_range(0, cur_h - 1),
                          $urandom_range(0, cur_w - 1));
            end
            else
            begin
                send_beat(mgd_pkg::OP_READ, $urandom_range(0, 31), $urandom_range(0, 31));
            end
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        operation    = mgd_pkg::OP_READ;
        cell_row     = '0;
        cell_column  = '0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        hold_request = 1'b0;
        cur_w        = 21;
        cur_h        = 21;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reads before any generate, then default maze
        send_beat(mgd_pkg::OP_READ, 0, 0);
        send_beat(mgd_pkg::OP_READ, 20, 20);
        send_beat(mgd_pkg::OP_READ, 21, 5);
        send_beat(mgd_pkg::OP_READ, 31, 31);
        send_beat(mgd_pkg::OP_GENERATE, 0, 0);
        send_beat(mgd_pkg::OP_READ, 1, 1);
        send_beat(mgd_pkg::OP_READ, 0, 10);
        send_beat(mgd_pkg::OP_READ, 10, 20);
        send_beat(mgd_pkg::OP_READ, 5, 21);
        drain();

        // smallest grid, zero seed
        set_grid(3, 3, 0);
        send_beat(mgd_pkg::OP_GENERATE, 31, 31);
        for (int r = 0; r < 4; r++)
        begin
            send_beat(mgd_pkg::OP_READ, r, 1);
        end
        send_beat(mgd_pkg::OP_READ, 1, 0);
        send_beat(mgd_pkg::OP_READ, 1, 2);
        drain();

        // largest grid, all-ones seed, long output hold-off under a random burst of reads and generates
        set_grid(31, 31, 16'hFFFF);
        send_beat(mgd_pkg::OP_GENERATE, 0, 0);
        drain();
        hold_request = 1'b1;
        random_beats(22);
        drain();

        // even sizes and tiny sizes
        set_grid(4, 8, $urandom_range(0, 65535));
        send_beat(mgd_pkg::OP_GENERATE, 0, 0);
        random_beats(20);
        drain();
        set_grid(0, 2, $urandom_range(0, 65535));
        send_beat(mgd_pkg::OP_GENERATE, 0, 0);
        random_beats(15);
        drain();

        for (int ph = 0; ph < 3; ph++)
        begin
            set_grid($urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 65535));
            send_beat(mgd_pkg::OP_GENERATE, 0, 0);
            random_beats(22);
            drain();
        end

        if (fail_count == 0 && pending == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
